### rtl/sfs_pkg.sv
// Package with the shared types and codes of the sprite animation frame sequencer.
`timescale 1ns / 1ps
package sfs_pkg;

  // Command codes of an input word.
  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_INSERT  = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  // Wrap mode codes.
  localparam logic [1:0] WRAP_CLAMP = 2'd0;
  localparam logic [1:0] WRAP_LOOP  = 2'd1;
  localparam logic [1:0] WRAP_PING  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_WRAP_MODE      = 1'b0;
  localparam logic CFG_START_REVERSED = 1'b1;

  // Width of the total duration and of the dividend magnitude.
  localparam int TOTAL_W = 22;
  localparam int TEST_W  = 34;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_INS_RD,
    ST_INS_WR,
    ST_MUL,
    ST_WRAP,
    ST_DIV,
    ST_DIV_FIN,
    ST_SR_INIT,
    ST_SR_RD,
    ST_SR_CMP,
    ST_LAST_RD,
    ST_LAST_CAP,
    ST_EMIT
  } sfs_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic decide;
    logic push_wr;
    logic ins_init;
    logic ins_rd;
    logic ins_wr;
    logic ins_final;
    logic zero_time;
    logic mul;
    logic wrap;
    logic div_step;
    logic div_fin;
    logic srch_init;
    logic srch_cmp;
    logic last_rd;
    logic last_cap;
    logic emit;
  } sfs_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic [1:0] mode;
    logic       ok;
    logic       tot_zero;
    logic       ins_more;
    logic       div_last;
    logic       cnt_zero;
    logic       match;
    logic       last_i;
  } sfs_stat_t;

endpackage

### rtl/sfs_ram.sv
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module sfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sfs_ctrl.sv
// Controller state machine of the sprite animation frame sequencer.
`timescale 1ns / 1ps
module sfs_ctrl import sfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  sfs_stat_t st,
  output sfs_ctrl_t c,
  output logic      busy
);

  sfs_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    c = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          c.latch = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        c.decide = 1'b1;
        state_next = ST_SR_INIT;
        if (st.op == CMD_PUSH) begin
          c.push_wr = st.ok;
        end else if (st.op == CMD_INSERT) begin
          if (st.ok) begin
            c.ins_init = 1'b1;
            state_next = ST_INS_RD;
          end
        end else if (st.op == CMD_ADVANCE) begin
          if (st.tot_zero) begin
            c.zero_time = 1'b1;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_INS_RD: begin
        if (st.ins_more) begin
          c.ins_rd = 1'b1;
          state_next = ST_INS_WR;
        end else begin
          c.ins_final = 1'b1;
          state_next = ST_SR_INIT;
        end
      end
      ST_INS_WR: begin
        c.ins_wr = 1'b1;
        state_next = ST_INS_RD;
      end
      ST_MUL: begin
        c.mul = 1'b1;
        state_next = ST_WRAP;
      end
      ST_WRAP: begin
        c.wrap = 1'b1;
        if (st.mode == WRAP_LOOP || st.mode == WRAP_PING) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_SR_INIT;
        end
      end
      ST_DIV: begin
        c.div_step = 1'b1;
        if (st.div_last) begin
          state_next = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        c.div_fin = 1'b1;
        state_next = ST_SR_INIT;
      end
      ST_SR_INIT: begin
        c.srch_init = 1'b1;
        state_next = st.cnt_zero ? ST_EMIT : ST_SR_RD;
      end
      ST_SR_RD: begin
        state_next = ST_SR_CMP;
      end
      ST_SR_CMP: begin
        c.srch_cmp = 1'b1;
        if (st.match) begin
          state_next = ST_EMIT;
        end else if (st.last_i) begin
          state_next = ST_LAST_RD;
        end else begin
          state_next = ST_SR_RD;
        end
      end
      ST_LAST_RD: begin
        c.last_rd = 1'b1;
        state_next = ST_LAST_CAP;
      end
      ST_LAST_CAP: begin
        c.last_cap = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        c.emit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/sfs_dp.sv
// Datapath of the sprite animation frame sequencer: frame table, time and search.
`timescale 1ns / 1ps
module sfs_dp import sfs_pkg::*; #(
  parameter int MAX_FRAMES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  sfs_ctrl_t          c,
  output sfs_stat_t          st,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_wdata,
  input  logic [1:0]         cmd,
  input  logic [15:0]        sprite_id,
  input  logic [15:0]        frame_ticks,
  input  logic [5:0]         position,
  input  logic [15:0]        delta_ticks,
  input  logic signed [15:0] speed,
  output logic               done,
  output logic               accepted,
  output logic               frame_valid,
  output logic [5:0]         frame_index,
  output logic [15:0]        frame_sprite,
  output logic signed [31:0] play_time,
  output logic               reversed
);

  localparam int IW = $clog2(MAX_FRAMES);
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int PW = (CW > 6) ? CW : 6;
  localparam int DCW = $clog2(TEST_W);

  // Latched input word.
  logic [1:0]         op_r;
  logic [15:0]        sid_r;
  logic [15:0]        dur_r;
  logic [5:0]         pos_r;
  logic [15:0]        delta_r;
  logic signed [15:0] speed_r;

  // Architectural state.
  logic [CW-1:0]      count;
  logic [TOTAL_W-1:0] total;
  logic signed [31:0] ctime;
  logic               toggle;
  logic [1:0]         wrap_mode;
  logic               start_rev;
  logic               acc;

  // Working registers.
  logic [IW-1:0]        ptr;
  logic signed [24:0]   step_r;
  logic [TEST_W-1:0]    dmag;
  logic                 dneg;
  logic [TOTAL_W-1:0]   rem;
  logic [DCW-1:0]       dcnt;
  logic [CW-1:0]        i_cnt;
  logic [31:0]          start_acc;
  logic [IW-1:0]        sel_idx;
  logic [15:0]          sel_spr;

  // RAM port signals.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic [PW-1:0]         pos_w, cnt_w;
  logic                  add_ok;
  logic [TOTAL_W:0]      tot_sum;
  logic [TOTAL_W-1:0]    tot_sat;
  logic signed [32:0]    prod;
  logic signed [TEST_W-1:0] test;
  logic                  test_ge_tot;
  logic                  under;
  logic [TOTAL_W:0]      dtrial;
  logic                  rev;
  logic [CW-1:0]         k_full, last_full;
  logic [IW-1:0]         k;
  logic [31:0]           end_acc;
  logic                  match;
  logic [PW-1:0]         idx_w;

  assign pos_w = PW'(pos_r);
  assign cnt_w = PW'(count);
  assign add_ok = (sid_r != 16'd0) && (count < CW'(MAX_FRAMES));
  assign tot_sum = {1'b0, total} + (TOTAL_W + 1)'(dur_r);
  assign tot_sat = tot_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tot_sum[TOTAL_W-1:0];

  // Speed product and the unwrapped new time.
  assign prod = $signed({1'b0, delta_r}) * speed_r;
  assign test = TEST_W'(ctime) + TEST_W'(step_r);
  assign test_ge_tot = test >= $signed({{(TEST_W - TOTAL_W){1'b0}}, total});
  assign under = test[TEST_W-1] && !(&test[TEST_W-2:31]);

  // One step of the restoring remainder.
  assign dtrial = {rem, dmag[TEST_W-1]};

  // Search order and span check.
  assign rev = start_rev ^ toggle;
  assign last_full = count - CW'(1);
  assign k_full = rev ? (last_full - i_cnt) : i_cnt;
  assign k = k_full[IW-1:0];
  assign end_acc = start_acc + 32'(ram_rdata[15:0]);
  assign match = !ctime[31] && ($unsigned(ctime) >= start_acc) && ($unsigned(ctime) < end_acc);

  // Status to the controller.
  always_comb begin
    st.op       = op_r;
    st.mode     = wrap_mode;
    st.tot_zero = (total == '0);
    st.ins_more = (PW'(ptr) > pos_w);
    st.div_last = (dcnt == '0);
    st.cnt_zero = (count == '0);
    st.match    = match;
    st.last_i   = (i_cnt == last_full);
    if (op_r == CMD_INSERT) begin
      st.ok = add_ok && (pos_w < cnt_w);
    end else begin
      st.ok = add_ok;
    end
  end

  // Frame table port selection.
  always_comb begin
    ram_we    = c.push_wr | c.ins_wr | c.ins_final;
    ram_waddr = ptr;
    ram_wdata = ram_rdata;
    if (c.push_wr) begin
      ram_waddr = count[IW-1:0];
      ram_wdata = {sid_r, dur_r};
    end else if (c.ins_final) begin
      ram_waddr = pos_w[IW-1:0];
      ram_wdata = {sid_r, dur_r};
    end
    if (c.ins_rd) begin
      ram_raddr = ptr - IW'(1);
    end else if (c.last_rd) begin
      ram_raddr = last_full[IW-1:0];
    end else begin
      ram_raddr = k;
    end
  end

  sfs_ram #(
    .WIDTH(32),
    .DEPTH(MAX_FRAMES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control state: table fill, total, time, direction and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      ctime     <= '0;
      toggle    <= 1'b0;
      wrap_mode <= WRAP_CLAMP;
      start_rev <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= c.emit;
      if (cfg_wr_en) begin
        if (cfg_index == CFG_WRAP_MODE) begin
          wrap_mode <= cfg_wdata;
        end else begin
          start_rev <= cfg_wdata[0];
        end
      end
      if (c.push_wr || c.ins_final) begin
        count <= count + CW'(1);
        total <= tot_sat;
      end
      if (c.zero_time) begin
        ctime <= '0;
      end
      if (c.wrap) begin
        if (wrap_mode == WRAP_CLAMP) begin
          if (test_ge_tot) begin
            ctime <= 32'(total);
          end else if (under) begin
            ctime <= 32'sh8000_0000;
          end else begin
            ctime <= test[31:0];
          end
        end else if (wrap_mode == WRAP_PING && test_ge_tot) begin
          toggle <= ~toggle;
        end
      end
      if (c.div_fin) begin
        if (dneg && rem != '0) begin
          ctime <= 32'(total - rem);
        end else begin
          ctime <= 32'(rem);
        end
      end
    end
  end

  // Working registers and the result word.
  always_ff @(posedge clk) begin
    if (c.latch) begin
      op_r    <= cmd;
      sid_r   <= sprite_id;
      dur_r   <= frame_ticks;
      pos_r   <= position;
      delta_r <= delta_ticks;
      speed_r <= speed;
    end
    if (c.decide) begin
      acc <= (op_r == CMD_ADVANCE) ||
             ((op_r == CMD_PUSH || op_r == CMD_INSERT) && st.ok);
    end
    if (c.ins_init) begin
      ptr <= count[IW-1:0];
    end
    if (c.ins_wr) begin
      ptr <= ptr - IW'(1);
    end
    if (c.mul) begin
      step_r <= 25'(prod >>> 8);
    end
    if (c.wrap) begin
      dneg <= test[TEST_W-1];
      dmag <= test[TEST_W-1] ? TEST_W'(-test) : TEST_W'(test);
      rem  <= '0;
      dcnt <= DCW'(TEST_W - 1);
    end
    if (c.div_step) begin
      dmag <= dmag << 1;
      dcnt <= dcnt - DCW'(1);
      if (dtrial >= {1'b0, total}) begin
        rem <= TOTAL_W'(dtrial - {1'b0, total});
      end else begin
        rem <= dtrial[TOTAL_W-1:0];
      end
    end
    if (c.srch_init) begin
      i_cnt     <= '0;
      start_acc <= '0;
      sel_idx   <= '0;
      sel_spr   <= '0;
    end
    if (c.srch_cmp) begin
      if (match) begin
        sel_idx <= k;
        sel_spr <= ram_rdata[31:16];
      end else begin
        start_acc <= end_acc;
        i_cnt     <= i_cnt + CW'(1);
      end
    end
    if (c.last_cap) begin
      sel_idx <= last_full[IW-1:0];
      sel_spr <= ram_rdata[31:16];
    end
    if (c.emit) begin
      accepted     <= acc;
      frame_valid  <= (count != '0);
      frame_index  <= idx_w[5:0];
      frame_sprite <= sel_spr;
      play_time    <= ctime;
      reversed     <= rev;
    end
  end

  assign idx_w = PW'(sel_idx);

endmodule

### rtl/sprite_animation_frame_sequencer.sv
// Top level of the sprite animation frame sequencer.
// A push or failed command is decided, then the frames are searched in order, the last taken if
// no span matches. An insert first shifts the entries from the position up by one, then places
// the frame; an advance adds a speed step and wrap, loop or ping-pong the bit-serial remainder.
// Throughput: one word at a time; busy stays high until the result strobe, set by the
// single table read port that the insert shift and the frame search share.
// Reset clears frame count, total, play time, direction and configuration; table contents stay.
`timescale 1ns / 1ps
module sprite_animation_frame_sequencer import sfs_pkg::*; #(
  parameter int MAX_FRAMES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_wdata,
  input  logic [1:0]         cmd,
  input  logic [15:0]        sprite_id,
  input  logic [15:0]        frame_ticks,
  input  logic [5:0]         position,
  input  logic [15:0]        delta_ticks,
  input  logic signed [15:0] speed,
  output logic               done,
  output logic               accepted,
  output logic               frame_valid,
  output logic [5:0]         frame_index,
  output logic [15:0]        frame_sprite,
  output logic signed [31:0] play_time,
  output logic               reversed
);

  sfs_ctrl_t ctrl;
  sfs_stat_t stat;

  // Sequencer.
  sfs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .st   (stat),
    .c    (ctrl),
    .busy (busy)
  );

  // Table, time and search datapath.
  sfs_dp #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .c           (ctrl),
    .st          (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .sprite_id   (sprite_id),
    .frame_ticks (frame_ticks),
    .position    (position),
    .delta_ticks (delta_ticks),
    .speed       (speed),
    .done        (done),
    .accepted    (accepted),
    .frame_valid (frame_valid),
    .frame_index (frame_index),
    .frame_sprite(frame_sprite),
    .play_time   (play_time),
    .reversed    (reversed)
  );

  // A result word only follows work on a started word.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result strobe without work in progress");

  // The strobe lasts one cycle and the block is then free.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while still busy");

  // An empty table selects nothing.
  a_empty_sel: assert property (@(posedge clk) disable iff (rst)
    done && !frame_valid |-> frame_index == 6'd0 && frame_sprite == 16'd0)
    else $error("selection reported on an empty table");

endmodule
